/* design/ordered_array_insert_delete_search_macros.svh */
// Assertion macros shared by the design files.
// Each macro checks one implication on the rising clock edge, outside reset.
`ifndef ORDERED_ARRAY_INSERT_DELETE_SEARCH_MACROS_SVH
`define ORDERED_ARRAY_INSERT_DELETE_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define OADIS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define OADIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define OADIS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define OADIS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/oadis_pkg.sv */
package oadis_pkg;

    // Storage size and derived widths.
    localparam int CAPACITY = 128;
    localparam int AddrW    = $clog2(CAPACITY);
    localparam int CntW     = $clog2(CAPACITY + 1);

    // Field widths of the input and result words.
    localparam int OpW      = 2;
    localparam int PosW     = 8;
    localparam int ValW     = 32;
    localparam int StatusW  = 3;
    localparam int FoundW   = 7;
    localparam int FillW    = 8;

    // Common width for comparing a position against the fill count.
    localparam int CmpW     = (PosW > CntW) ? PosW : CntW;

    // Operation codes.
    localparam logic [OpW-1:0] OP_INSERT = 2'd0;
    localparam logic [OpW-1:0] OP_DELETE = 2'd1;
    localparam logic [OpW-1:0] OP_SEARCH = 2'd2;

    // Status codes.
    localparam logic [StatusW-1:0] ST_OK       = 3'd0;
    localparam logic [StatusW-1:0] ST_FULL     = 3'd1;
    localparam logic [StatusW-1:0] ST_EMPTY    = 3'd2;
    localparam logic [StatusW-1:0] ST_BADPOS   = 3'd3;
    localparam logic [StatusW-1:0] ST_NOTFOUND = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic shift_up;
        logic ins_write;
        logic shift_dn;
        logic search;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic early_ok;
        logic ptr_above_pos;
        logic ptr_below_last;
        logic ptr_below_count;
        logic hit;
        logic out_free;
    } t_sts;

endpackage

/* design/ordered_array_insert_delete_search.sv */
// Positional array of up to 128 signed 32-bit entries with a fill count, held in
// one single-port-write RAM with a registered read. Each word asks for insert at a
// position, delete at a position, or a linear search for a value, and gives one
// result word with status, found index and the fill count after the operation.
// One operation is in work at a time. An insert moves each entry at or above the
// position up by one, top first, then writes the value; a delete moves the entries
// above the position down by one; a search compares entries from index 0 until one
// matches or the fill count is reached. A word rejected by the full, empty, position
// or operation checks goes straight to the result. A result that finds the output
// register still occupied waits until it is free. The RAM moves or compares one entry
// per cycle. The next word is taken once the result has been placed in the output
// register, even if it has not yet been collected. The fill count resets to zero.
module ordered_array_insert_delete_search (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [oadis_pkg::OpW-1:0]           i_operation,
    input  logic [oadis_pkg::PosW-1:0]          i_position,
    input  logic signed [oadis_pkg::ValW-1:0]   i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [oadis_pkg::StatusW-1:0]       o_status,
    output logic [oadis_pkg::FoundW-1:0]        o_found_index,
    output logic [oadis_pkg::FillW-1:0]         o_fill_count
);

    import oadis_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencing of each operation.
    oadis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Storage, pointers, checks and the result register.
    oadis_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_fill_count  (o_fill_count)
    );

endmodule

/* design/oadis_ram.sv */
module oadis_ram #(
    parameter int Width = 32,
    parameter int Depth = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/oadis_ctrl.sv */
`include "ordered_array_insert_delete_search_macros.svh"

module oadis_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [oadis_pkg::OpW-1:0] i_operation,
    input  oadis_pkg::t_sts           i_sts,
    output oadis_pkg::t_cmd           o_cmd
);

    import oadis_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_INS_WRITE,
        S_SHIFT_DN,
        S_SEARCH,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    // Next state and the commands issued in each state.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                cmd.start = i_in_valid;
                if (i_in_valid) begin
                    if (!i_sts.early_ok) begin
                        n_state = S_DONE;
                    end else begin
                        case (i_operation)
                            OP_INSERT: n_state = S_SHIFT_UP;
                            OP_DELETE: n_state = S_SHIFT_DN;
                            OP_SEARCH: n_state = S_SEARCH;
                            default:   n_state = S_DONE;
                        endcase
                    end
                end
            end
            S_SHIFT_UP: begin
                cmd.shift_up = 1'b1;
                if (!i_sts.ptr_above_pos) begin
                    n_state = S_INS_WRITE;
                end
            end
            S_INS_WRITE: begin
                cmd.ins_write = 1'b1;
                n_state       = S_DONE;
            end
            S_SHIFT_DN: begin
                cmd.shift_dn = 1'b1;
                if (!i_sts.ptr_below_last) begin
                    n_state = S_DONE;
                end
            end
            S_SEARCH: begin
                cmd.search = 1'b1;
                if (i_sts.hit || !i_sts.ptr_below_count) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hand the result over once the output register is free.
                if (i_sts.out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);

    // A result word is never loaded over one that is still waiting.
    `OADIS_ASSERT_NOW(a_load_free, i_clk, i_rst_n, cmd.load_out, i_sts.out_free)

endmodule

/* design/oadis_dp.sv */
`include "ordered_array_insert_delete_search_macros.svh"

module oadis_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [oadis_pkg::OpW-1:0]       i_operation,
    input  logic [oadis_pkg::PosW-1:0]      i_position,
    input  logic signed [oadis_pkg::ValW-1:0] i_value,
    input  oadis_pkg::t_cmd                 i_cmd,
    output oadis_pkg::t_sts                 o_sts,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [oadis_pkg::StatusW-1:0]   o_status,
    output logic [oadis_pkg::FoundW-1:0]    o_found_index,
    output logic [oadis_pkg::FillW-1:0]     o_fill_count
);

    import oadis_pkg::*;

    // Working registers of the current operation.
    logic [PosW-1:0]    r_pos;
    logic [ValW-1:0]    r_val;
    logic [CntW-1:0]    r_ptr;
    logic               r_pend;
    logic [AddrW-1:0]   r_wr_addr;
    logic [AddrW-1:0]   r_cmp_idx;
    logic [CntW-1:0]    r_count;
    logic [StatusW-1:0] r_status;
    logic [FoundW-1:0]  r_found;

    // Output register.
    logic               r_out_valid;
    logic [StatusW-1:0] r_out_status;
    logic [FoundW-1:0]  r_out_found;
    logic [FillW-1:0]   r_out_fill;

    // Memory port signals.
    logic               we;
    logic [AddrW-1:0]   waddr;
    logic [ValW-1:0]    wdata;
    logic [AddrW-1:0]   raddr;
    logic [ValW-1:0]    rdata;

    logic [StatusW-1:0] early_status;
    logic [CmpW-1:0]    count_x;
    logic [CmpW-1:0]    pos_in_x;
    logic [CmpW-1:0]    ptr_x;
    logic [CmpW-1:0]    pos_x;
    logic [CntW-1:0]    ptr_inc;
    logic [CntW-1:0]    ptr_dec;
    logic               hit;

    assign count_x  = CmpW'(r_count);
    assign pos_in_x = CmpW'(i_position);
    assign ptr_x    = CmpW'(r_ptr);
    assign pos_x    = CmpW'(r_pos);
    assign ptr_inc  = r_ptr + CntW'(1);
    assign ptr_dec  = r_ptr - CntW'(1);
    assign hit      = r_pend && (rdata == r_val);

    // Checks on the incoming word that are settled before any memory access.
    always_comb begin
        case (i_operation)
            OP_INSERT: begin
                if (r_count >= CntW'(CAPACITY)) begin
                    early_status = ST_FULL;
                end else if (pos_in_x > count_x) begin
                    early_status = ST_BADPOS;
                end else begin
                    early_status = ST_OK;
                end
            end
            OP_DELETE: begin
                if (r_count == '0) begin
                    early_status = ST_EMPTY;
                end else if (pos_in_x >= count_x) begin
                    early_status = ST_BADPOS;
                end else begin
                    early_status = ST_OK;
                end
            end
            OP_SEARCH: early_status = ST_OK;
            default:   early_status = ST_BADPOS;
        endcase
    end

    // Status towards the controller.
    always_comb begin
        o_sts                 = '0;
        o_sts.early_ok        = (early_status == ST_OK);
        o_sts.ptr_above_pos   = (ptr_x > pos_x);
        o_sts.ptr_below_last  = (ptr_inc < r_count);
        o_sts.ptr_below_count = (r_ptr < r_count);
        o_sts.hit             = hit;
        o_sts.out_free        = !r_out_valid || i_out_ready;
    end

    // Memory addressing: a shift writes back the entry read in the cycle before.
    always_comb begin
        we    = 1'b0;
        waddr = r_wr_addr;
        wdata = rdata;
        raddr = '0;
        if ((i_cmd.shift_up || i_cmd.shift_dn) && r_pend) begin
            we = 1'b1;
        end
        if (i_cmd.ins_write) begin
            we    = 1'b1;
            waddr = AddrW'(r_pos);
            wdata = r_val;
        end
        if (i_cmd.shift_up) begin
            raddr = ptr_dec[AddrW-1:0];
        end else if (i_cmd.shift_dn) begin
            raddr = ptr_inc[AddrW-1:0];
        end else if (i_cmd.search) begin
            raddr = r_ptr[AddrW-1:0];
        end
    end

    oadis_ram #(
        .Width (ValW),
        .Depth (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Operation registers, fill count and the result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_pos    <= i_position;
                r_val    <= i_value;
                r_status <= early_status;
                r_found  <= '0;
                r_pend   <= 1'b0;
                case (i_operation)
                    OP_INSERT: r_ptr <= r_count;
                    OP_DELETE: r_ptr <= CntW'(i_position);
                    default:   r_ptr <= '0;
                endcase
            end

            // Walk down from the top, moving each entry up by one.
            if (i_cmd.shift_up) begin
                if (o_sts.ptr_above_pos) begin
                    r_pend    <= 1'b1;
                    r_wr_addr <= r_ptr[AddrW-1:0];
                    r_ptr     <= ptr_dec;
                end else begin
                    r_pend <= 1'b0;
                end
            end

            if (i_cmd.ins_write) begin
                r_count <= r_count + CntW'(1);
            end

            // Walk up from the position, moving each entry down by one.
            if (i_cmd.shift_dn) begin
                if (o_sts.ptr_below_last) begin
                    r_pend    <= 1'b1;
                    r_wr_addr <= r_ptr[AddrW-1:0];
                    r_ptr     <= ptr_inc;
                end else begin
                    r_pend  <= 1'b0;
                    r_count <= r_count - CntW'(1);
                end
            end

            // Read one entry a cycle and compare it in the next.
            if (i_cmd.search) begin
                if (hit) begin
                    r_status <= ST_OK;
                    r_found  <= FoundW'(r_cmp_idx);
                    r_pend   <= 1'b0;
                end else if (o_sts.ptr_below_count) begin
                    r_pend    <= 1'b1;
                    r_cmp_idx <= r_ptr[AddrW-1:0];
                    r_ptr     <= ptr_inc;
                end else begin
                    r_status <= ST_NOTFOUND;
                    r_pend   <= 1'b0;
                end
            end

            if (i_cmd.load_out) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_status;
                r_out_found  <= r_found;
                r_out_fill   <= FillW'(r_count);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_index = r_out_found;
    assign o_fill_count  = r_out_fill;

    `OADIS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CntW'(CAPACITY))
    `OADIS_ASSERT_NOW(a_found_zero, i_clk, i_rst_n, r_out_valid && (r_out_status != ST_OK), r_out_found == '0)
    `OADIS_ASSERT_NEXT(a_ins_count, i_clk, i_rst_n, i_cmd.ins_write, r_count == $past(r_count) + CntW'(1))

endmodule

/* tb/sv/testbench.sv */
module testbench;

    import oadis_pkg::*;

    // The package names only the three live operations; the block rejects the spare code with ST_BADPOS.
    localparam logic [OpW-1:0] OP_RESERVED = 2'd3;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 9;
    localparam int LIMIT_CYC   = 2_000_000;
    localparam int SETTLE_CYC  = CAPACITY + 8;
    localparam int HOLD_CYC    = 400;

    typedef logic signed [ValW-1:0] t_value;

    typedef struct {
        logic [StatusW-1:0] status;
        logic [FoundW-1:0]  found_index;
        logic [FillW-1:0]   fill_count;
    } t_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [OpW-1:0]        i_operation = OP_INSERT;
    logic [PosW-1:0]       i_position = '0;
    t_value                i_value = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [StatusW-1:0]    o_status;
    logic [FoundW-1:0]     o_found_index;
    logic [FillW-1:0]      o_fill_count;

    // Mirror of the array contents and fill count, updated as each word is taken.
    t_value                shadow_entries [CAPACITY];
    int                    shadow_count = 0;
    t_outcome              outcome_q [$];

    int                    error_count = 0;
    int                    cycle_count = 0;
    int                    send_idle_pct = 38;
    int                    recv_idle_pct = 38;
    int                    hold_len = 0;
    bit                    growing = 1'b1;

    ordered_array_insert_delete_search DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_fill_count  (o_fill_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Applies one operation to the mirror and returns the result word it should give.
    function automatic t_outcome array_op_outcome(logic [OpW-1:0] op, logic [PosW-1:0] pos,
                                                  t_value val);
        t_outcome res;
        int       i;
        bit       hit;
        res.status      = ST_OK;
        res.found_index = '0;
        hit             = 1'b0;
        case (op)
            OP_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (int'(pos) > shadow_count) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (i = shadow_count; i > int'(pos); i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[pos] = val;
                    shadow_count++;
                end
            end
            OP_DELETE: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (int'(pos) >= shadow_count) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (i = int'(pos); i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                end
            end
            OP_SEARCH: begin
                res.status = ST_NOTFOUND;
                for (i = 0; i < shadow_count && !hit; i++) begin
                    if (shadow_entries[i] == val) begin
                        hit             = 1'b1;
                        res.status      = ST_OK;
                        res.found_index = i[FoundW-1:0];
                    end
                end
            end
            default: res.status = ST_BADPOS;
        endcase
        res.fill_count = shadow_count[FillW-1:0];
        return res;
    endfunction

    function automatic bit value_present(t_value val);
        bit found;
        found = 1'b0;
        for (int i = 0; i < shadow_count; i++)
            if (shadow_entries[i] == val) found = 1'b1;
        return found;
    endfunction

    // Values lean on a small pool so that duplicates and search hits are common.
    function automatic t_value pick_value();
        int     r;
        t_value val;
        r = $urandom_range(99);
        if (r < 40) begin
            val = t_value'($urandom_range(15)) - 8;
        end else if (r < 50) begin
            case ($urandom_range(3))
                0: val = 32'sh8000_0000;
                1: val = 32'sh7FFF_FFFF;
                2: val = '0;
                default: val = '1;
            endcase
        end else begin
            val = t_value'($urandom);
        end
        return val;
    endfunction

    // Offers one word after a random gap and waits until the block takes it.
    task automatic send_word(logic [OpW-1:0] op, logic [PosW-1:0] pos, t_value val);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        i_value     <= val;
        do @(posedge i_clk); while (!o_in_ready);
        outcome_q.push_back(array_op_outcome(op, pos, val));
    endtask

    // Stops offering words and waits until every outstanding result has been collected.
    task automatic wait_all_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
    endtask

    // One random word, biased to fill the array up and then empty it again.
    task automatic send_random_word();
        int             r;
        logic [OpW-1:0] op;
        logic [PosW-1:0] pos;
        t_value         val;
        if (shadow_count >= CAPACITY) growing = 1'b0;
        if (shadow_count == 0) growing = 1'b1;
        r = $urandom_range(99);
        if (r < (growing ? 60 : 12))
            op = OP_INSERT;
        else if (r < 72)
            op = OP_DELETE;
        else if (r < 97)
            op = OP_SEARCH;
        else
            op = OP_RESERVED;
        r   = $urandom_range(99);
        pos = PosW'($urandom_range(255));
        if (op == OP_INSERT && r < 80)
            pos = PosW'($urandom_range(shadow_count));
        else if (op == OP_INSERT && r < 85)
            pos = PosW'(shadow_count);
        else if (op == OP_DELETE && r < 85 && shadow_count > 0)
            pos = PosW'($urandom_range(shadow_count - 1));
        val = pick_value();
        if (op == OP_SEARCH && shadow_count > 0 && $urandom_range(1) == 1)
            val = shadow_entries[$urandom_range(shadow_count - 1)];
        send_word(op, pos, val);
    endtask

    // Edge cases on an empty and a short array.
    task automatic test_directed();
        send_word(OP_SEARCH,   8'd0,   32'sd0);
        send_word(OP_DELETE,   8'd0,   32'sd0);
        send_word(OP_DELETE,   8'd255, 32'sd0);
        send_word(OP_INSERT,   8'd1,   32'sd1);
        send_word(OP_INSERT,   8'd255, 32'sd1);
        send_word(OP_RESERVED, 8'd0,   32'sd0);
        send_word(OP_INSERT,   8'd0,   32'sd5);
        send_word(OP_INSERT,   8'd1,   32'sh7FFF_FFFF);
        send_word(OP_INSERT,   8'd0,   32'sh8000_0000);
        send_word(OP_INSERT,   8'd1,   -32'sd1);
        send_word(OP_INSERT,   8'd2,   32'sd5);
        send_word(OP_INSERT,   8'd6,   32'sd9);
        send_word(OP_SEARCH,   8'd255, 32'sd5);
        send_word(OP_SEARCH,   8'd0,   32'sh7FFF_FFFF);
        send_word(OP_SEARCH,   8'd0,   32'sh8000_0000);
        send_word(OP_SEARCH,   8'd0,   32'sd0);
        send_word(OP_RESERVED, 8'd255, -32'sd1);
        send_word(OP_DELETE,   8'd5,   32'sd0);
        send_word(OP_DELETE,   8'd255, 32'sd0);
        send_word(OP_DELETE,   8'd4,   32'sd0);
        send_word(OP_DELETE,   8'd0,   32'sd0);
        send_word(OP_DELETE,   8'd1,   32'sd0);
        send_word(OP_SEARCH,   8'd0,   -32'sd1);
        wait_all_results();
    endtask

    // Fills the array to capacity, probes the full cases, then drains it to empty.
    task automatic test_fill_and_drain();
        t_value val;
        while (shadow_count < CAPACITY - 1)
            send_word(OP_INSERT, PosW'($urandom_range(shadow_count)), pick_value());
        // A value unique to the top entry makes the search walk the whole array.
        do val = t_value'($urandom); while (value_present(val));
        send_word(OP_INSERT, PosW'(shadow_count), val);
        send_word(OP_SEARCH, 8'd0, val);
        send_word(OP_INSERT, 8'd0, 32'sd1);
        send_word(OP_INSERT, 8'd255, 32'sd1);
        send_word(OP_DELETE, 8'd128, 32'sd0);
        send_word(OP_DELETE, 8'd255, 32'sd0);
        do val = t_value'($urandom); while (value_present(val));
        send_word(OP_SEARCH, 8'd0, val);
        while (shadow_count > 0)
            send_word(OP_DELETE, PosW'($urandom_range(shadow_count - 1)), 32'sd0);
        send_word(OP_DELETE, 8'd0, 32'sd0);
        wait_all_results();
    endtask

    task automatic test_random_mix(int n_words);
        repeat (n_words) send_random_word();
        wait_all_results();
    endtask

    // Neither side idles, so words and results move at the block's full rate.
    task automatic test_back_to_back(int n_words);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (n_words) send_random_word();
        wait_all_results();
        send_idle_pct = 38;
        recv_idle_pct = 38;
    endtask

    // The receiver stops collecting while words keep coming, so the block backs up.
    task automatic test_output_hold();
        hold_len = HOLD_CYC;
        repeat (10) send_random_word();
        wait_all_results();
    endtask

    // Result collection, with random stalls or a long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_len) @(negedge i_clk);
                hold_len = 0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Each collected result word is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_outcome exp_w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (outcome_q.size() == 0) begin
                $error("result word with no prediction outstanding");
                error_count++;
            end else begin
                exp_w = outcome_q.pop_front();
                if (o_status !== exp_w.status) begin
                    $error("status: expected %0d, got %0d", exp_w.status, o_status);
                    error_count++;
                end
                if (o_found_index !== exp_w.found_index) begin
                    $error("found_index: expected %0d, got %0d",
                           exp_w.found_index, o_found_index);
                    error_count++;
                end
                if (o_fill_count !== exp_w.fill_count) begin
                    $error("fill_count: expected %0d, got %0d",
                           exp_w.fill_count, o_fill_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYC) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (RESET_LEN) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_fill_and_drain();
        test_random_mix(1250);
        test_output_hold();
        test_back_to_back(200);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
